/* src/s3g_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3g_pkg
// Shared types, constants, S-boxes and GF(2^8) helpers for the SNOW 3G core.
// ----------------------------------------------------------------------------
package s3g_pkg;

    localparam int INIT_ROUNDS = 32;
    localparam int MAX_WORDS   = 64;
    localparam int ROUND_W     = $clog2(INIT_ROUNDS);
    localparam int COUNT_W     = 7;
    localparam int NUM_REGS    = 8;
    localparam int ADDR_W      = $clog2(NUM_REGS) + 2;

    localparam logic [7:0] POLY_ALPHA = 8'ha9;
    localparam logic [7:0] POLY_S1    = 8'h1b;
    localparam logic [7:0] POLY_S2    = 8'h69;

    // register indexes
    localparam logic [$clog2(NUM_REGS)-1:0] REG_KEY0 = 3'd0;
    localparam logic [$clog2(NUM_REGS)-1:0] REG_KEY1 = 3'd1;
    localparam logic [$clog2(NUM_REGS)-1:0] REG_KEY2 = 3'd2;
    localparam logic [$clog2(NUM_REGS)-1:0] REG_KEY3 = 3'd3;
    localparam logic [$clog2(NUM_REGS)-1:0] REG_IV0  = 3'd4;
    localparam logic [$clog2(NUM_REGS)-1:0] REG_IV1  = 3'd5;
    localparam logic [$clog2(NUM_REGS)-1:0] REG_IV2  = 3'd6;
    localparam logic [$clog2(NUM_REGS)-1:0] REG_IV3  = 3'd7;

    // request codes
    localparam logic REQ_INIT = 1'b0;
    localparam logic REQ_GEN  = 1'b1;

    typedef logic [3:0][31:0] quad_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // load LFSR from key/iv, clear FSM
        logic step;      // clock FSM and LFSR
        logic feedback;  // feed F into the LFSR (init mode)
        logic emit;      // capture z = F ^ s0 into the output register
        logic last;      // last word of the run
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_full;
    } status_t;

    localparam logic [7:0] AES_BOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,
        8'hab,8'h76,8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,
        8'h9c,8'ha4,8'h72,8'hc0,8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,
        8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,
        8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,8'h53,8'hd1,8'h00,8'hed,
        8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,8'hd0,8'hef,
        8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,
        8'hf3,8'hd2,8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,
        8'h64,8'h5d,8'h19,8'h73,8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,
        8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,
        8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,8'hba,8'h78,8'h25,8'h2e,
        8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,8'h70,8'h3e,
        8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,
        8'h28,8'hdf,8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,
        8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] SQ_BOX [256] = '{
        8'h25,8'h24,8'h73,8'h67,8'hd7,8'hae,8'h5c,8'h30,8'ha4,8'hee,8'h6e,8'hcb,8'h7d,8'hb5,
        8'h82,8'hdb,8'he4,8'h8e,8'h48,8'h49,8'h4f,8'h5d,8'h6a,8'h78,8'h70,8'h88,8'he8,8'h5f,
        8'h5e,8'h84,8'h65,8'he2,8'hd8,8'he9,8'hcc,8'hed,8'h40,8'h2f,8'h11,8'h28,8'h57,8'hd2,
        8'hac,8'he3,8'h4a,8'h15,8'h1b,8'hb9,8'hb2,8'h80,8'h85,8'ha6,8'h2e,8'h02,8'h47,8'h29,
        8'h07,8'h4b,8'h0e,8'hc1,8'h51,8'haa,8'h89,8'hd4,8'hca,8'h01,8'h46,8'hb3,8'hef,8'hdd,
        8'h44,8'h7b,8'hc2,8'h7f,8'hbe,8'hc3,8'h9f,8'h20,8'h4c,8'h64,8'h83,8'ha2,8'h68,8'h42,
        8'h13,8'hb4,8'h41,8'hcd,8'hba,8'hc6,8'hbb,8'h6d,8'h4d,8'h71,8'h21,8'hf4,8'h8d,8'hb0,
        8'he5,8'h93,8'hfe,8'h8f,8'he6,8'hcf,8'h43,8'h45,8'h31,8'h22,8'h37,8'h36,8'h96,8'hfa,
        8'hbc,8'h0f,8'h08,8'h52,8'h1d,8'h55,8'h1a,8'hc5,8'h4e,8'h23,8'h69,8'h7a,8'h92,8'hff,
        8'h5b,8'h5a,8'heb,8'h9a,8'h1c,8'ha9,8'hd1,8'h7e,8'h0d,8'hfc,8'h50,8'h8a,8'hb6,8'h62,
        8'hf5,8'h0a,8'hf8,8'hdc,8'h03,8'h3c,8'h0c,8'h39,8'hf1,8'hb8,8'hf3,8'h3d,8'hf2,8'hd5,
        8'h97,8'h66,8'h81,8'h32,8'ha0,8'h00,8'h06,8'hce,8'hf6,8'hea,8'hb7,8'h17,8'hf7,8'h8c,
        8'h79,8'hd6,8'ha7,8'hbf,8'h8b,8'h3f,8'h1f,8'h53,8'h63,8'h75,8'h35,8'h2c,8'h60,8'hfd,
        8'h27,8'hd3,8'h94,8'ha5,8'h7c,8'ha1,8'h05,8'h58,8'h2d,8'hbd,8'hd9,8'hc7,8'haf,8'h6b,
        8'h54,8'h0b,8'he0,8'h38,8'h04,8'hc8,8'h9d,8'he7,8'h14,8'hb1,8'h87,8'h9c,8'hdf,8'h6f,
        8'hf9,8'hda,8'h2a,8'hc4,8'h59,8'h16,8'h74,8'h91,8'hab,8'h26,8'h61,8'h76,8'h34,8'h2b,
        8'had,8'h99,8'hfb,8'h72,8'hec,8'h33,8'h12,8'hde,8'h98,8'h3b,8'hc0,8'h9b,8'h3e,8'h18,
        8'h10,8'h3a,8'h56,8'he1,8'h77,8'hc9,8'h1e,8'h9e,8'h95,8'ha3,8'h90,8'h19,8'ha8,8'h6c,
        8'h09,8'hd0,8'hf0,8'h86};

    function automatic logic [7:0] xtime(input logic [7:0] v, input logic [7:0] poly);
        logic [7:0] r;
        r = {v[6:0], 1'b0};
        return v[7] ? (r ^ poly) : r;
    endfunction

    // elaboration only: v * x^n in GF(2^8) mod 0xa9
    function automatic logic [7:0] xpow(input logic [7:0] v, input int n);
        logic [7:0] r;
        r = v;
        for (int k = 0; k < n; k++) begin
            r = xtime(r, POLY_ALPHA);
        end
        return r;
    endfunction

    function automatic logic [31:0] mul_alpha_c(input logic [7:0] c);
        return {xpow(c, 23), xpow(c, 245), xpow(c, 48), xpow(c, 239)};
    endfunction

    function automatic logic [31:0] div_alpha_c(input logic [7:0] c);
        return {xpow(c, 16), xpow(c, 39), xpow(c, 6), xpow(c, 64)};
    endfunction

    // both maps are GF(2)-linear in c: one basis word per input bit
    localparam logic [31:0] MUL_BASIS [8] = '{
        mul_alpha_c(8'h01), mul_alpha_c(8'h02), mul_alpha_c(8'h04), mul_alpha_c(8'h08),
        mul_alpha_c(8'h10), mul_alpha_c(8'h20), mul_alpha_c(8'h40), mul_alpha_c(8'h80)};

    localparam logic [31:0] DIV_BASIS [8] = '{
        div_alpha_c(8'h01), div_alpha_c(8'h02), div_alpha_c(8'h04), div_alpha_c(8'h08),
        div_alpha_c(8'h10), div_alpha_c(8'h20), div_alpha_c(8'h40), div_alpha_c(8'h80)};

    function automatic logic [31:0] mul_alpha(input logic [7:0] c);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (c[i]) r = r ^ MUL_BASIS[i];
        end
        return r;
    endfunction

    function automatic logic [31:0] div_alpha(input logic [7:0] c);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (c[i]) r = r ^ DIV_BASIS[i];
        end
        return r;
    endfunction

    function automatic logic [31:0] mix_bytes(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c, input logic [7:0] d,
                                              input logic [7:0] poly);
        logic [7:0] xa, xb, xc, xd;
        xa = xtime(a, poly);
        xb = xtime(b, poly);
        xc = xtime(c, poly);
        xd = xtime(d, poly);
        return {xa ^ b ^ c ^ xd ^ d,
                xa ^ a ^ xb ^ c ^ d,
                a ^ xb ^ b ^ xc ^ d,
                a ^ b ^ xc ^ c ^ xd};
    endfunction

    function automatic logic [31:0] s1_word(input logic [31:0] w);
        return mix_bytes(AES_BOX[w[31:24]], AES_BOX[w[23:16]], AES_BOX[w[15:8]],
                         AES_BOX[w[7:0]], POLY_S1);
    endfunction

    function automatic logic [31:0] s2_word(input logic [31:0] w);
        return mix_bytes(SQ_BOX[w[31:24]], SQ_BOX[w[23:16]], SQ_BOX[w[15:8]],
                         SQ_BOX[w[7:0]], POLY_S2);
    endfunction

endpackage

/* src/snow3g_keystream_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snow3g_keystream_generator
// SNOW 3G keystream generator core (UEA2 keystream, no f9 MAC).
// ----------------------------------------------------------------------------
// Usage:
//   Program key_word_0..3 (byte address 4*i) and iv_word_0..3 (16 + 4*i)
//   over APB, then send an item on the s_ channel with s_req_type = 0
//   (init). Init loads the LFSR, clears R1..R3 and runs 32 feedback rounds:
//   the block is busy through its load and init states and gives no item.
//   An item with s_req_type = 1 (generate) runs the prelude state, then
//   emits s_word_count words (saturated at 64; zero gives none) on the m_
//   channel, m_last set on the final one. The first word goes through the
//   prelude and emit states into the output register; with m_ready held
//   high one word follows per cycle.
//   One LFSR/FSM clock per cycle sets the rate; s_ready is high only
//   between requests.
//   A stall on m_ready freezes the LFSR and FSM; the pending word sits in
//   the output register and the next one is computed when it is taken.
//   Reset (aresetn low, synchronous) clears key, IV, LFSR and FSM to zero;
//   a generate before any init runs on that all-zero state.
// ----------------------------------------------------------------------------
module snow3g_keystream_generator (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic [s3g_pkg::COUNT_W-1:0]  s_word_count,
    // keystream channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [31:0]                  m_keystream_word,
    output logic                         m_last,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [s3g_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    s3g_pkg::quad_t   key;
    s3g_pkg::quad_t   iv;
    s3g_pkg::cmd_t    cmd;
    s3g_pkg::status_t status;

    // key/IV register file
    s3g_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key     (key),
        .iv      (iv)
    );

    // sequencer: decides load / step / emit each cycle
    s3g_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_word_count (s_word_count),
        .m_ready      (m_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // LFSR, FSM and output register
    s3g_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .key              (key),
        .iv               (iv),
        .m_keystream_word (m_keystream_word),
        .m_last           (m_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready)
    );

endmodule

/* src/s3g_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3g_regs
// APB register file holding the four key words and four IV words.
// ----------------------------------------------------------------------------
module s3g_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [s3g_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output s3g_pkg::quad_t              key,
    output s3g_pkg::quad_t              iv
);

    s3g_pkg::quad_t key_reg, key_next;
    s3g_pkg::quad_t iv_reg,  iv_next;
    logic [$clog2(s3g_pkg::NUM_REGS)-1:0] idx;
    logic wr_en;

    assign idx    = paddr[s3g_pkg::ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb begin
        key_next = key_reg;
        iv_next  = iv_reg;
        if (wr_en) begin
            unique case (idx)
                s3g_pkg::REG_KEY0: key_next[0] = pwdata;
                s3g_pkg::REG_KEY1: key_next[1] = pwdata;
                s3g_pkg::REG_KEY2: key_next[2] = pwdata;
                s3g_pkg::REG_KEY3: key_next[3] = pwdata;
                s3g_pkg::REG_IV0:  iv_next[0]  = pwdata;
                s3g_pkg::REG_IV1:  iv_next[1]  = pwdata;
                s3g_pkg::REG_IV2:  iv_next[2]  = pwdata;
                s3g_pkg::REG_IV3:  iv_next[3]  = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            s3g_pkg::REG_KEY0: prdata = key_reg[0];
            s3g_pkg::REG_KEY1: prdata = key_reg[1];
            s3g_pkg::REG_KEY2: prdata = key_reg[2];
            s3g_pkg::REG_KEY3: prdata = key_reg[3];
            s3g_pkg::REG_IV0:  prdata = iv_reg[0];
            s3g_pkg::REG_IV1:  prdata = iv_reg[1];
            s3g_pkg::REG_IV2:  prdata = iv_reg[2];
            s3g_pkg::REG_IV3:  prdata = iv_reg[3];
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            iv_reg  <= '0;
        end else begin
            key_reg <= key_next;
            iv_reg  <= iv_next;
        end
    end

    assign key = key_reg;
    assign iv  = iv_reg;

endmodule

/* src/s3g_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3g_datapath
// 16-word LFSR, three-word FSM and the keystream output register.
// ----------------------------------------------------------------------------
module s3g_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  s3g_pkg::cmd_t      cmd,
    output s3g_pkg::status_t   status,
    input  s3g_pkg::quad_t     key,
    input  s3g_pkg::quad_t     iv,
    output logic [31:0]        m_keystream_word,
    output logic               m_last,
    output logic               m_valid,
    input  logic               m_ready
);

    logic [31:0] lfsr_reg [16];
    logic [31:0] lfsr_next [16];
    logic [31:0] r1_reg, r1_next;
    logic [31:0] r2_reg, r2_next;
    logic [31:0] r3_reg, r3_next;
    logic [31:0] f_word;
    logic [31:0] fb_word;
    logic [31:0] z_reg, z_next;
    logic        last_reg, last_next;
    logic        valid_reg, valid_next;

    assign f_word  = (lfsr_reg[15] + r1_reg) ^ r2_reg;
    assign fb_word = ({lfsr_reg[0][23:0], 8'h00}) ^ s3g_pkg::mul_alpha(lfsr_reg[0][31:24])
                   ^ lfsr_reg[2] ^ ({8'h00, lfsr_reg[11][31:8]})
                   ^ s3g_pkg::div_alpha(lfsr_reg[11][7:0])
                   ^ (cmd.feedback ? f_word : 32'h0);

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            lfsr_next[i] = lfsr_reg[i];
        end
        r1_next = r1_reg;
        r2_next = r2_reg;
        r3_next = r3_reg;
        if (cmd.load) begin
            lfsr_next[15] = key[3] ^ iv[0];
            lfsr_next[14] = key[2];
            lfsr_next[13] = key[1];
            lfsr_next[12] = key[0] ^ iv[1];
            lfsr_next[11] = ~key[3];
            lfsr_next[10] = ~key[2] ^ iv[2];
            lfsr_next[9]  = ~key[1] ^ iv[3];
            lfsr_next[8]  = ~key[0];
            lfsr_next[7]  = key[3];
            lfsr_next[6]  = key[2];
            lfsr_next[5]  = key[1];
            lfsr_next[4]  = key[0];
            lfsr_next[3]  = ~key[3];
            lfsr_next[2]  = ~key[2];
            lfsr_next[1]  = ~key[1];
            lfsr_next[0]  = ~key[0];
            r1_next = '0;
            r2_next = '0;
            r3_next = '0;
        end else if (cmd.step) begin
            for (int i = 0; i < 15; i++) begin
                lfsr_next[i] = lfsr_reg[i+1];
            end
            lfsr_next[15] = fb_word;
            r1_next = r2_reg + (r3_reg ^ lfsr_reg[5]);
            r2_next = s3g_pkg::s1_word(r1_reg);
            r3_next = s3g_pkg::s2_word(r2_reg);
        end
    end

    // output register: holds one word until taken
    always_comb begin
        z_next     = z_reg;
        last_next  = last_reg;
        valid_next = valid_reg & ~m_ready;
        if (cmd.emit) begin
            z_next     = f_word ^ lfsr_reg[0];
            last_next  = cmd.last;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                lfsr_reg[i] <= '0;
            end
            r1_reg    <= '0;
            r2_reg    <= '0;
            r3_reg    <= '0;
            valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < 16; i++) begin
                lfsr_reg[i] <= lfsr_next[i];
            end
            r1_reg    <= r1_next;
            r2_reg    <= r2_next;
            r3_reg    <= r3_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        z_reg    <= z_next;
        last_reg <= last_next;
    end

    assign status.out_full  = valid_reg;
    assign m_keystream_word = z_reg;
    assign m_last           = last_reg;
    assign m_valid          = valid_reg;

`ifndef ASSERT_OFF
    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!valid_reg || m_ready))
        else $error("emit while output word not taken");

    a_emit_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (cmd.step && !cmd.feedback && !cmd.load))
        else $error("emit without a keystream-mode step");

    a_valid_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(valid_reg) |-> $past(cmd.emit))
        else $error("output valid without emit");
`endif

endmodule

/* src/s3g_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3g_ctrl
// Request sequencer: init rounds, generate prelude and word emission.
// ----------------------------------------------------------------------------
module s3g_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [s3g_pkg::COUNT_W-1:0]   s_word_count,
    input  logic                          m_ready,
    input  s3g_pkg::status_t              status,
    output s3g_pkg::cmd_t                 cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_LOAD    = 5'b00010,
        ST_INIT    = 5'b00100,
        ST_PRELUDE = 5'b01000,
        ST_EMIT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [s3g_pkg::ROUND_W-1:0] round_reg, round_next;
    logic [s3g_pkg::COUNT_W-1:0] left_reg, left_next;
    logic [s3g_pkg::COUNT_W-1:0] count_sat;
    logic accept;
    logic out_go;

    localparam logic [s3g_pkg::COUNT_W-1:0] MAX_CNT = s3g_pkg::COUNT_W'(s3g_pkg::MAX_WORDS);
    localparam logic [s3g_pkg::ROUND_W-1:0] LAST_ROUND =
        s3g_pkg::ROUND_W'(s3g_pkg::INIT_ROUNDS - 1);
    localparam logic [s3g_pkg::ROUND_W-1:0] ONE_ROUND = s3g_pkg::ROUND_W'(1);
    localparam logic [s3g_pkg::COUNT_W-1:0] ONE_CNT = s3g_pkg::COUNT_W'(1);

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid & s_ready;
    assign count_sat = (s_word_count > MAX_CNT) ? MAX_CNT : s_word_count;
    assign out_go    = ~status.out_full | m_ready;

    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        left_next    = left_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_req_type == s3g_pkg::REQ_INIT) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_PRELUDE;
                        left_next  = count_sat;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                round_next = '0;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                cmd.step     = 1'b1;
                cmd.feedback = 1'b1;
                round_next   = round_reg + ONE_ROUND;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_IDLE;
                    left_next  = '0;
                end
            end
            ST_PRELUDE: begin
                // discarded FSM clock plus one keystream-mode LFSR clock
                cmd.step   = 1'b1;
                state_next = (left_reg == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_go) begin
                    cmd.step  = 1'b1;
                    cmd.emit  = 1'b1;
                    cmd.last  = (left_reg == ONE_CNT);
                    left_next = left_reg - ONE_CNT;
                    if (left_reg == ONE_CNT) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            left_reg  <= '0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            left_reg  <= left_next;
        end
    end

`ifndef ASSERT_OFF
    a_emit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (left_reg != '0))
        else $error("emit state with no words left");

    a_load_to_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |=> (state_reg == ST_INIT && round_reg == '0))
        else $error("load not followed by round zero");

    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= MAX_CNT)
        else $error("word counter beyond maximum");
`endif

endmodule

/* bench/snow3g_keystream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snow3g_keystream_checker
// Watches the request, keystream and APB ports of the SNOW 3G core, runs
// its own copy of the LFSR/FSM on every accepted request and compares each
// keystream item against the oldest predicted word.
// ----------------------------------------------------------------------------
module snow3g_keystream_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [s3g_pkg::COUNT_W-1:0] s_word_count,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [31:0]                 m_keystream_word,
    input  logic                        m_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [s3g_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          fail_count,
    output int                          pending_words
);

    localparam int INIT_CLOCKS = 32;
    localparam logic [6:0] WORD_CAP = 7'd64;

    localparam logic [2047:0] RIJNDAEL_BOX = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

    localparam logic [2047:0] SQ_MAP = {
        128'h25247367d7ae5c30a4ee6ecb7db582db, 128'he48e48494f5d6a787088e85f5e8465e2,
        128'hd8e9cced402f112857d2ace34a151bb9, 128'hb28085a62e024729074b0ec151aa89d4,
        128'hca0146b3efdd447bc27fbec39f204c64, 128'h83a2684213b441cdbac6bb6d4d7121f4,
        128'h8db0e593fe8fe6cf43453122373696fa, 128'hbc0f08521d551ac54e23697a92ff5b5a,
        128'heb9a1ca9d17e0dfc508ab662f50af8dc, 128'h033c0c39f1b8f33df2d597668132a000,
        128'h06cef6eab717f78c79d6a7bf8b3f1f53, 128'h6375352c60fd27d394a57ca105582dbd,
        128'hd9c7af6b540be03804c89de714b1879c, 128'hdf6ff9da2ac459167491ab266176342b,
        128'had99fb72ec3312de983bc09b3e18103a, 128'h56e177c91e9e95a39019a86c09d0f086};

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } ks_word_t;

    ks_word_t    ks_due [$];
    logic [31:0] key_sh [4];
    logic [31:0] iv_sh [4];
    logic [31:0] lfsr [16];
    logic [31:0] r1, r2, r3;
    logic [31:0] alpha_mul_tbl [256];
    logic [31:0] alpha_div_tbl [256];
    int          mismatches;

    assign fail_count = mismatches;

    function automatic logic [7:0] gf_dbl(input logic [7:0] v, input logic [7:0] poly);
        return v[7] ? ({v[6:0], 1'b0} ^ poly) : {v[6:0], 1'b0};
    endfunction

    function automatic logic [7:0] times_x(input logic [7:0] v, input int n);
        logic [7:0] r;
        r = v;
        for (int k = 0; k < n; k++) r = gf_dbl(r, 8'ha9);
        return r;
    endfunction

    // S-box lookup followed by the column mix: coefficient 2 on byte i,
    // 3 on byte i-1, 1 on the other two
    function automatic logic [31:0] box_mix(input logic [31:0] w, input logic use_sq);
        logic [7:0]  x [4];
        logic [7:0]  d [4];
        logic [7:0]  poly;
        logic [31:0] res;
        int          idx;
        poly = use_sq ? 8'h69 : 8'h1b;
        for (int i = 0; i < 4; i++) begin
            idx  = int'(w[31 - 8 * i -: 8]);
            x[i] = use_sq ? SQ_MAP[(255 - idx) * 8 +: 8] : RIJNDAEL_BOX[(255 - idx) * 8 +: 8];
            d[i] = gf_dbl(x[i], poly);
        end
        for (int i = 0; i < 4; i++) begin
            res[31 - 8 * i -: 8] = d[i] ^ d[(i + 3) % 4] ^ x[(i + 3) % 4] ^
                                   x[(i + 1) % 4] ^ x[(i + 2) % 4];
        end
        return res;
    endfunction

    initial begin
        logic [7:0] cb;
        for (int c = 0; c < 256; c++) begin
            cb = 8'(c);
            alpha_mul_tbl[c] = {times_x(cb, 23), times_x(cb, 245),
                                times_x(cb, 48), times_x(cb, 239)};
            alpha_div_tbl[c] = {times_x(cb, 16), times_x(cb, 39),
                                times_x(cb, 6), times_x(cb, 64)};
        end
    end

    task automatic fsm_advance(output logic [31:0] f);
        logic [31:0] nxt;
        f   = (lfsr[15] + r1) ^ r2;
        nxt = r2 + (r3 ^ lfsr[5]);
        r3  = box_mix(r2, 1'b1);
        r2  = box_mix(r1, 1'b0);
        r1  = nxt;
    endtask

    task automatic lfsr_advance(input logic [31:0] f);
        logic [31:0] v;
        v = {lfsr[0][23:0], 8'h00} ^ alpha_mul_tbl[lfsr[0][31:24]] ^ lfsr[2] ^
            {8'h00, lfsr[11][31:8]} ^ alpha_div_tbl[lfsr[11][7:0]] ^ f;
        for (int i = 0; i < 15; i++) lfsr[i] = lfsr[i + 1];
        lfsr[15] = v;
    endtask

    task automatic load_key_iv();
        lfsr[15] = key_sh[3] ^ iv_sh[0];
        lfsr[14] = key_sh[2];
        lfsr[13] = key_sh[1];
        lfsr[12] = key_sh[0] ^ iv_sh[1];
        lfsr[11] = ~key_sh[3];
        lfsr[10] = ~key_sh[2] ^ iv_sh[2];
        lfsr[9]  = ~key_sh[1] ^ iv_sh[3];
        lfsr[8]  = ~key_sh[0];
        lfsr[7]  = key_sh[3];
        lfsr[6]  = key_sh[2];
        lfsr[5]  = key_sh[1];
        lfsr[4]  = key_sh[0];
        lfsr[3]  = ~key_sh[3];
        lfsr[2]  = ~key_sh[2];
        lfsr[1]  = ~key_sh[1];
        lfsr[0]  = ~key_sh[0];
        r1 = '0;
        r2 = '0;
        r3 = '0;
    endtask

    task automatic predict_request(input logic req, input logic [6:0] count);
        logic [31:0] f;
        logic [6:0]  n;
        ks_word_t    w;
        if (req == s3g_pkg::REQ_INIT) begin
            load_key_iv();
            for (int r = 0; r < INIT_CLOCKS; r++) begin
                fsm_advance(f);
                lfsr_advance(f);
            end
        end else begin
            n = (count > WORD_CAP) ? WORD_CAP : count;
            // prelude: discarded FSM output, keystream-mode LFSR clock
            fsm_advance(f);
            lfsr_advance('0);
            while (n != 0) begin
                fsm_advance(f);
                n      = n - 7'd1;
                w.word = f ^ lfsr[0];
                w.last = (n == 0);
                ks_due.push_back(w);
                lfsr_advance('0);
            end
        end
    endtask

    always @(posedge aclk) begin
        logic [2:0] reg_idx;
        ks_word_t   want;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                key_sh[i] = '0;
                iv_sh[i]  = '0;
            end
            for (int i = 0; i < 16; i++) lfsr[i] = '0;
            r1 = '0;
            r2 = '0;
            r3 = '0;
            ks_due.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_idx = paddr[s3g_pkg::ADDR_W-1:2];
                case (reg_idx)
                    s3g_pkg::REG_KEY0: key_sh[0] = pwdata;
                    s3g_pkg::REG_KEY1: key_sh[1] = pwdata;
                    s3g_pkg::REG_KEY2: key_sh[2] = pwdata;
                    s3g_pkg::REG_KEY3: key_sh[3] = pwdata;
                    s3g_pkg::REG_IV0:  iv_sh[0]  = pwdata;
                    s3g_pkg::REG_IV1:  iv_sh[1]  = pwdata;
                    s3g_pkg::REG_IV2:  iv_sh[2]  = pwdata;
                    s3g_pkg::REG_IV3:  iv_sh[3]  = pwdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (ks_due.size() == 0) begin
                    $error("keystream item with none expected: word %h last %b",
                           m_keystream_word, m_last);
                    mismatches = mismatches + 1;
                end else begin
                    want = ks_due.pop_front();
                    if (m_keystream_word !== want.word) begin
                        $error("keystream_word: expected %h, got %h",
                               want.word, m_keystream_word);
                        mismatches = mismatches + 1;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_last);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (s_valid && s_ready) predict_request(s_req_type, s_word_count);
        end
        pending_words <= ks_due.size();
    end

endmodule

/* bench/tb_snow3g_keystream_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_snow3g_keystream_generator
// Stimulus and verdict for the SNOW 3G keystream core: programs key and IV
// over APB, sends init and generate requests with random gaps and stalls,
// and leaves prediction and comparison to the checker beside the core.
// ----------------------------------------------------------------------------
module tb_snow3g_keystream_generator;

    localparam int CYCLE_LIMIT  = 2_000_000; // far above the slowest correct run
    localparam int RANDOM_ITEMS = 420;
    localparam int LONG_HOLD    = 300;       // receiver stall that backs up the core
    localparam int SETTLE       = 40;        // lets a pending init run to its end

    logic                        aclk;
    logic                        aresetn = 1'b0;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_req_type;
    logic [s3g_pkg::COUNT_W-1:0] s_word_count;
    logic                        m_valid;
    logic                        m_ready;
    logic [31:0]                 m_keystream_word;
    logic                        m_last;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [s3g_pkg::ADDR_W-1:0]  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    int   fail_count;
    int   words_pending;
    int   cycle_count = 0;
    int   items_sent  = 0;
    // shared with the receiver: no idling in this phase / one long stall asked
    logic steady_flow = 1'b0;
    logic rx_hold_req = 1'b0;

    snow3g_keystream_generator u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_word_count     (s_word_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_keystream_word (m_keystream_word),
        .m_last           (m_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    snow3g_keystream_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_word_count     (s_word_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_keystream_word (m_keystream_word),
        .m_last           (m_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .fail_count       (fail_count),
        .pending_words    (words_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake or a missing word ends here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver. Per item it draws a random wait with m_ready low, unless
    // the phase runs steady. A long stall request from the stimulus side is
    // served here, counted locally, while the sender keeps pushing requests
    // so the output register fills and s_ready drops.
    // ------------------------------------------------------------------
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                gap = LONG_HOLD;
            end else if (steady_flow) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 10);
            end
            // only one assignment to m_ready per time step
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // One request item. s_valid is left high after the accept so a
    // back-to-back item does not lower and raise it in the same step;
    // it drops only at the start of a gap or when the sender goes idle.
    task automatic send_request(input logic req, input logic [6:0] count);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_word_count <= count;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent = items_sent + 1;
    endtask

    // Setup cycle then access cycle; psel stays high across back-to-back
    // writes and is dropped by the caller.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    // Only called while the core is idle.
    task automatic program_key_iv(input logic [31:0] k0, input logic [31:0] k1,
                                  input logic [31:0] k2, input logic [31:0] k3,
                                  input logic [31:0] v0, input logic [31:0] v1,
                                  input logic [31:0] v2, input logic [31:0] v3);
        apb_write(s3g_pkg::REG_KEY0, k0);
        apb_write(s3g_pkg::REG_KEY1, k1);
        apb_write(s3g_pkg::REG_KEY2, k2);
        apb_write(s3g_pkg::REG_KEY3, k3);
        apb_write(s3g_pkg::REG_IV0, v0);
        apb_write(s3g_pkg::REG_IV1, v1);
        apb_write(s3g_pkg::REG_IV2, v2);
        apb_write(s3g_pkg::REG_IV3, v3);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sender pauses until every predicted word has come out, then lets an
    // init (which emits nothing) finish before anything else happens.
    // The checker's count is registered, hence the first wait.
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mostly short runs; zero, the cap and counts past it show up too.
    function automatic logic [6:0] pick_count();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5) return 7'd0;
        if (sel < 10) return 7'($urandom_range(65, 127));
        if (sel < 20) return 7'd64;
        if (sel < 70) return 7'($urandom_range(1, 8));
        return 7'($urandom_range(9, 63));
    endfunction

    initial begin
        int          n_items;
        int          phase;
        int          key_kind;
        logic [31:0] kw [8];

        s_valid      <= 1'b0;
        s_req_type   <= s3g_pkg::REQ_INIT;
        s_word_count <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;

        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // generate on the all-zero state left by reset, no init yet
        send_request(s3g_pkg::REQ_GEN, 7'd1);
        send_request(s3g_pkg::REQ_GEN, 7'd3);
        send_request(s3g_pkg::REQ_GEN, 7'd0);
        wait_for_idle();

        // all-ones key and IV; init ignores its word count
        program_key_iv('1, '1, '1, '1, '1, '1, '1, '1);
        send_request(s3g_pkg::REQ_INIT, 7'h7f);
        send_request(s3g_pkg::REQ_GEN, 7'd64);
        send_request(s3g_pkg::REQ_GEN, 7'd0);   // prelude only, no words
        send_request(s3g_pkg::REQ_GEN, 7'd127); // saturates at the cap
        send_request(s3g_pkg::REQ_GEN, 7'd65);
        send_request(s3g_pkg::REQ_GEN, 7'd1);
        send_request(s3g_pkg::REQ_INIT, 7'd0);
        send_request(s3g_pkg::REQ_GEN, 7'd5);
        wait_for_idle();

        // zero key against an all-ones IV, back-to-back inits
        steady_flow = 1'b1;
        program_key_iv('0, '0, '0, '0, '1, '1, '1, '1);
        send_request(s3g_pkg::REQ_INIT, 7'd64);
        send_request(s3g_pkg::REQ_GEN, 7'd16);
        send_request(s3g_pkg::REQ_INIT, 7'd1);
        send_request(s3g_pkg::REQ_INIT, 7'd0);
        send_request(s3g_pkg::REQ_GEN, 7'd2);
        send_request(s3g_pkg::REQ_GEN, 7'd64);
        wait_for_idle();

        // ---- random phases ----
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            phase       = phase + 1;
            steady_flow = ($urandom_range(0, 4) == 0);
            key_kind    = $urandom_range(0, 9);
            for (int i = 0; i < 8; i++) begin
                if (key_kind == 0) kw[i] = '0;
                else if (key_kind == 1) kw[i] = '1;
                else kw[i] = $urandom();
            end
            program_key_iv(kw[0], kw[1], kw[2], kw[3], kw[4], kw[5], kw[6], kw[7]);

            // most phases start from a fresh init; a few keep the old state
            if ($urandom_range(0, 9) != 0) send_request(s3g_pkg::REQ_INIT, pick_count());

            // one long receiver stall while requests keep coming
            if (phase == 2) rx_hold_req = 1'b1;

            n_items = $urandom_range(15, 40);
            repeat (n_items) begin
                if ($urandom_range(0, 9) == 0) send_request(s3g_pkg::REQ_INIT, pick_count());
                else send_request(s3g_pkg::REQ_GEN, pick_count());
            end
            wait_for_idle();
        end

        if (fail_count == 0 && words_pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
